FILE: rtl/fpc_pkg.sv
// Package for the fractal palette colorizer: palette codes, angle multipliers,
// and the quarter-wave sine table function. No dependencies.
package fpc_pkg;

    localparam int SineTableDepthDefault = 1024;
    localparam int TFracBitsDefault      = 15;

    typedef enum logic [2:0] {
        PAL_CLASSIC = 3'd0,
        PAL_BLUE    = 3'd1,
        PAL_FIRE    = 3'd2,
        PAL_PSYCH   = 3'd3,
        PAL_GRAY    = 3'd4
    } palette_t;

    localparam logic [1:0] REG_PALETTE = 2'd0;
    localparam logic [1:0] REG_PHASE   = 2'd1;

    // Multipliers that turn t into turn units (65536 = one turn).
    localparam logic [17:0] MUL_K4   = 18'd41722;
    localparam logic [17:0] MUL_K5   = 18'd52152;
    localparam logic [17:0] MUL_K6   = 18'd62582;
    localparam logic [17:0] MUL_K8   = 18'd83443;
    localparam logic [17:0] MUL_K12  = 18'd125165;
    localparam logic [17:0] MUL_K16  = 18'd166886;
    localparam logic [17:0] MUL_TURN = 18'd65536;
    localparam logic [17:0] MUL_HALF = 18'd32768;

    localparam logic [16:0] PH_X05 = 17'd32768;
    localparam logic [16:0] PH_X07 = 17'd45875;
    localparam logic [16:0] PH_X13 = 17'd85197;

    localparam logic [15:0] OFS_1RAD  = 16'd10430;
    localparam logic [15:0] OFS_2RAD  = 16'd20861;
    localparam logic [15:0] OFS_2094  = 16'd21841;
    localparam logic [15:0] OFS_4188  = 16'd43682;
    localparam logic [15:0] OFS_QUART = 16'd16384;

    function automatic longint mul_q30(longint a, longint b);
        longint mag;
        longint p;
        mag = (a < 0) ? -a : a;
        p = (mag * b + (64'sd1 <<< 29)) >>> 30;
        return (a < 0) ? -p : p;
    endfunction

    // Quarter-wave table entry: sin(pi/2 * x) in Q0.15, with x the table
    // position in Q30. Evaluated only at elaboration to fill a constant table.
    function automatic logic [14:0] quarter_sine(longint x);
        longint x2;
        longint acc;
        longint v;
        x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
        acc = -3864;
        acc = 172272 + mul_q30(acc, x2);
        acc = -5026995 + mul_q30(acc, x2);
        acc = 85569306 + mul_q30(acc, x2);
        acc = -693598668 + mul_q30(acc, x2);
        acc = 1686629713 + mul_q30(acc, x2);
        v = mul_q30(acc, x);
        if (v < 0)
        begin
            v = 0;
        end
        v = (v + 16384) >>> 15;
        if (v > 32767)
        begin
            v = 32767;
        end
        return v[14:0];
    endfunction

endpackage

FILE: rtl/fpc_sine.sv
// Quarter-wave sine lookup, one register stage: angle in turns in, signed Q2.15 out.
// Depends on fpc_pkg for the table function.
module fpc_sine #(
    parameter int SINE_TABLE_DEPTH = fpc_pkg::SineTableDepthDefault
) (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [16:0] sine
);
    localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MulW = 14 + IdxW;

    logic [14:0] rom [SINE_TABLE_DEPTH + 1];

    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++)
    begin : g_rom
        localparam longint XPos = (longint'(i) <<< 30) / SINE_TABLE_DEPTH;
        assign rom[i] = fpc_pkg::quarter_sine(XPos);
    end

    logic [MulW-1:0] prod;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] ridx;
    logic [14:0]     mag;
    logic signed [16:0] sine_next;
    logic signed [16:0] sine_reg;

    always_comb
    begin
        prod = MulW'(angle[13:0]) * MulW'(SINE_TABLE_DEPTH) + MulW'(8192);
        idx  = IdxW'(prod >> 14);
        if (idx > IdxW'(SINE_TABLE_DEPTH))
        begin
            idx = IdxW'(SINE_TABLE_DEPTH);
        end
        ridx = angle[14] ? IdxW'(SINE_TABLE_DEPTH) - idx : idx;
        mag  = rom[ridx];
        sine_next = angle[15] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;
endmodule

FILE: rtl/fractal_palette_colorizer.sv
// Top level of the fractal palette colorizer: four-stage pixel pipeline.
// Depends on fpc_pkg and fpc_sine.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------
//  pixel in | in_valid  | in_stall  | t_value
//  color out| out_valid | out_stall | red, green, blue
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
// One pixel can enter every cycle while in_stall is low; each goes from input
// to output through angle products, angle sums, sine table, channel scale and
// clamp. Each stage advances when it is empty or the next one advances, so a
// stall holds the full stages back to the first bubble, nothing is lost or repeated,
// and bubbles are squeezed out. Reset clears valid, palette and phase to zero.
module fractal_palette_colorizer #(
    parameter int SINE_TABLE_DEPTH = fpc_pkg::SineTableDepthDefault,
    parameter int T_FRAC_BITS      = fpc_pkg::TFracBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] t_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    localparam int F = T_FRAC_BITS;

    logic [2:0]  palette_reg;
    logic [15:0] phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= '0;
            phase_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fpc_pkg::REG_PALETTE)
            begin
                palette_reg <= cfg_data[2:0];
            end
            else if (cfg_index == fpc_pkg::REG_PHASE)
            begin
                phase_reg <= cfg_data;
            end
        end
    end

    // Valid bits for the four stages; a stage moves when it is empty or the next one moves.
    logic [3:0] v_reg;
    logic       adv [4];
    assign adv[3] = !v_reg[3] || !out_stall;
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign adv[0] = !v_reg[0] || adv[1];
    assign in_stall  = !adv[0];
    assign out_valid = v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    // Stage 1: t times three palette multipliers, and the two scaled phases.
    logic [17:0] m0, m1, m2;
    logic [16:0] pm;
    always_comb
    begin
        m0 = fpc_pkg::MUL_K5;
        m1 = fpc_pkg::MUL_K5;
        m2 = fpc_pkg::MUL_K5;
        pm = fpc_pkg::PH_X05;
        unique case (palette_reg)
            fpc_pkg::PAL_BLUE:
            begin
                m0 = fpc_pkg::MUL_K4;
                m1 = fpc_pkg::MUL_K6;
                m2 = fpc_pkg::MUL_K8;
            end
            fpc_pkg::PAL_FIRE:
            begin
                m0 = fpc_pkg::MUL_K12;
                m1 = fpc_pkg::MUL_K16;
                m2 = fpc_pkg::MUL_K16;
                pm = fpc_pkg::PH_X13;
            end
            fpc_pkg::PAL_PSYCH:
            begin
                m0 = fpc_pkg::MUL_TURN;
                m1 = fpc_pkg::MUL_TURN;
                m2 = fpc_pkg::MUL_TURN;
            end
            fpc_pkg::PAL_GRAY:
            begin
                m0 = fpc_pkg::MUL_HALF;
                m1 = fpc_pkg::MUL_HALF;
                m2 = fpc_pkg::MUL_HALF;
            end
            default:
            begin
            end
        endcase
    end

    logic [33:0] p0_reg, p1_reg, p2_reg;
    logic [32:0] pa_reg, pb_reg;
    logic [15:0] t1_reg;
    logic [2:0]  pal1_reg;
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p0_reg   <= 34'(t_value) * 34'(m0);
            p1_reg   <= 34'(t_value) * 34'(m1);
            p2_reg   <= 34'(t_value) * 34'(m2);
            pa_reg   <= 33'(phase_reg) * 33'(pm);
            pb_reg   <= 33'(phase_reg) * 33'(fpc_pkg::PH_X07);
            t1_reg   <= t_value;
            pal1_reg <= palette_reg;
        end
    end

    // Stage 2: round the products into angles and add the phases.
    logic [15:0] a0, a1, a2, sp, sq, ang0, ang1, ang2;
    logic [33:0] rnd;
    always_comb
    begin
        rnd  = 34'(1) << (F - 1);
        a0   = 16'((p0_reg + rnd) >> F);
        a1   = 16'((p1_reg + rnd) >> F);
        a2   = 16'((p2_reg + rnd) >> F);
        sp   = 16'((pa_reg + 33'd32768) >> 16);
        sq   = 16'((pb_reg + 33'd32768) >> 16);
        ang0 = a0 + phase_reg;
        ang1 = a1 + phase_reg;
        ang2 = a2 + phase_reg;
        unique case (pal1_reg)
            fpc_pkg::PAL_BLUE:
            begin
                ang0 = a0 + sp;
                ang1 = a1 + fpc_pkg::OFS_1RAD + sq;
                ang2 = a2 + fpc_pkg::OFS_2RAD + phase_reg;
            end
            fpc_pkg::PAL_FIRE:
            begin
                ang2 = a1 + sp;
            end
            fpc_pkg::PAL_PSYCH:
            begin
                ang1 = a0 + phase_reg + fpc_pkg::OFS_2094;
                ang2 = a0 + phase_reg + fpc_pkg::OFS_4188;
            end
            fpc_pkg::PAL_GRAY:
            begin
                ang0 = a0 + phase_reg + fpc_pkg::OFS_QUART;
            end
            default:
            begin
            end
        endcase
    end

    logic [15:0] ang0_reg, ang1_reg, ang2_reg, t2_reg;
    logic [2:0]  pal2_reg;
    logic [31:0] tt2_reg;
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            ang0_reg <= ang0;
            ang1_reg <= ang1;
            ang2_reg <= ang2;
            t2_reg   <= t1_reg;
            tt2_reg  <= 32'(t1_reg) * 32'(t1_reg);
            pal2_reg <= pal1_reg;
        end
    end

    // Stage 3: sine lookups, registered inside the lookup units.
    logic signed [16:0] s0, s1, s2;
    fpc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin0
        (.clk(clk), .en(adv[2]), .angle(ang0_reg), .sine(s0));
    fpc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin1
        (.clk(clk), .en(adv[2]), .angle(ang1_reg), .sine(s1));
    fpc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sin2
        (.clk(clk), .en(adv[2]), .angle(ang2_reg), .sine(s2));

    logic [15:0] t3_reg;
    logic [2:0]  pal3_reg;
    logic [38:0] tt3_reg;
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            t3_reg   <= t2_reg;
            tt3_reg  <= 39'(tt2_reg) * 39'd100;
            pal3_reg <= pal2_reg;
        end
    end

    // Stage 4: offset plus gain times sine, truncate, clamp; fire scales t and t squared instead.
    function automatic logic [7:0] level(logic [9:0] off2, logic [9:0] gain2,
                                         logic signed [16:0] s);
        logic signed [28:0] v;
        logic [12:0]        u;
        v = $signed({4'b0, off2, 15'b0}) + $signed({1'b0, gain2}) * s;
        u = 13'(v >>> 16);
        if (v < 0)
        begin
            return 8'd0;
        end
        return (u > 13'd255) ? 8'd255 : u[7:0];
    endfunction

    logic [17:0] fs1, fs2;
    logic [41:0] fg;
    logic [56:0] fb;
    logic [41:0] fgs;
    logic [56:0] fbs;
    logic [7:0]  r_next, g_next, b_next;
    always_comb
    begin
        fs1 = 18'($signed(18'd65536) + 18'(s0));
        fs2 = 18'($signed(18'd65536) + 18'(s2));
        fg  = 42'(t3_reg) * 42'd150 * 42'(fs1);
        fb  = 57'(tt3_reg) * 57'(fs2);
        fgs = fg >> (F + 16);
        fbs = (fb >> F) >> (F + 16);
        r_next = level(10'd400, 10'd110, s0);
        g_next = r_next;
        b_next = 8'd255;
        unique case (pal3_reg)
            fpc_pkg::PAL_BLUE:
            begin
                r_next = level(10'd160, 10'd120, s0);
                g_next = level(10'd240, 10'd160, s1);
                b_next = level(10'd440, 10'd70, s2);
            end
            fpc_pkg::PAL_FIRE:
            begin
                r_next = 8'd255;
                g_next = (fgs > 42'd255) ? 8'd255 : fgs[7:0];
                b_next = (fbs > 57'd255) ? 8'd255 : fbs[7:0];
            end
            fpc_pkg::PAL_PSYCH:
            begin
                r_next = level(10'd255, 10'd255, s0);
                g_next = level(10'd255, 10'd255, s1);
                b_next = level(10'd255, 10'd255, s2);
            end
            fpc_pkg::PAL_GRAY:
            begin
                r_next = level(10'd255, 10'd255, s0);
                g_next = r_next;
                b_next = r_next;
            end
            default:
            begin
            end
        endcase
    end

    logic [7:0] red_reg, green_reg, blue_reg;
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            red_reg   <= r_next;
            green_reg <= g_next;
            blue_reg  <= b_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
endmodule

FILE: tb/fractal_palette_colorizer_check.sv
// Color checker for the fractal palette colorizer: predicts each pixel's color
// from the accepted t value and the register copies, and compares outputs.
// Depends on fpc_pkg for palette codes, register indexes and angle constants.
`timescale 1ns / 1ps

module fractal_palette_colorizer_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] t_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output int          fail_count,
    output int          pending_colors
);
    localparam int DEPTH = 1024;
    localparam int FRAC  = 15;

    logic [2:0]  pal_copy;
    logic [15:0] phase_copy;
    logic [23:0] color_queue[$];
    longint      wave_rom[DEPTH + 1];

    function automatic longint round_q30(longint a, longint b);
        longint mag;
        longint p;
        mag = (a < 0) ? -a : a;
        p = (mag * b + (64'sd1 <<< 29)) >>> 30;
        return (a < 0) ? -p : p;
    endfunction

    function automatic longint taylor_sine(longint x);
        longint x2;
        longint acc;
        longint v;
        x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
        acc = -3864;
        acc = 172272 + round_q30(acc, x2);
        acc = -5026995 + round_q30(acc, x2);
        acc = 85569306 + round_q30(acc, x2);
        acc = -693598668 + round_q30(acc, x2);
        acc = 1686629713 + round_q30(acc, x2);
        v = round_q30(acc, x);
        if (v < 0)
        begin
            return 0;
        end
        v = (v + 16384) >>> 15;
        return (v > 32767) ? 32767 : v;
    endfunction

    initial
    begin
        for (int i = 0; i <= DEPTH; i++)
        begin
            wave_rom[i] = taylor_sine((longint'(i) <<< 30) / DEPTH);
        end
    end

    function automatic longint turn_sine(longint angle);
        longint a;
        longint quad;
        longint idx;
        a = angle & 16'hFFFF;
        quad = a >> 14;
        idx = ((a & 16'h3FFF) * DEPTH + 8192) >> 14;
        if (idx > DEPTH)
        begin
            idx = DEPTH;
        end
        if (quad[0])
        begin
            idx = DEPTH - idx;
        end
        return quad[1] ? -wave_rom[idx] : wave_rom[idx];
    endfunction

    function automatic longint t_turns(longint t, longint mult);
        return ((t * mult + (64'sd1 <<< (FRAC - 1))) >> FRAC) & 16'hFFFF;
    endfunction

    function automatic longint scaled_turns(longint m);
        return ((longint'(phase_copy) * m + 32768) >> 16) & 16'hFFFF;
    endfunction

    function automatic longint channel_level(longint off2, longint gain2, longint s);
        longint v;
        v = off2 * 32768 + gain2 * s;
        if (v < 0)
        begin
            return 0;
        end
        v = v >> 16;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic longint sat8(longint v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic logic [23:0] predict_color(longint t);
        longint r;
        longint g;
        longint b;
        longint s;
        longint ph;
        longint tp;
        tp = phase_copy;
        case (pal_copy)
            fpc_pkg::PAL_BLUE:
            begin
                r = channel_level(160, 120, turn_sine(t_turns(t, fpc_pkg::MUL_K4)
                    + scaled_turns(fpc_pkg::PH_X05)));
                g = channel_level(240, 160, turn_sine(t_turns(t, fpc_pkg::MUL_K6)
                    + fpc_pkg::OFS_1RAD + scaled_turns(fpc_pkg::PH_X07)));
                b = channel_level(440, 70, turn_sine(t_turns(t, fpc_pkg::MUL_K8)
                    + fpc_pkg::OFS_2RAD + tp));
            end
            fpc_pkg::PAL_FIRE:
            begin
                r = 255;
                s = turn_sine(t_turns(t, fpc_pkg::MUL_K12) + tp);
                g = sat8((150 * t * (65536 + s)) >> (FRAC + 16));
                s = turn_sine(t_turns(t, fpc_pkg::MUL_K16) + scaled_turns(fpc_pkg::PH_X13));
                b = sat8(((100 * t * t * (65536 + s)) >> FRAC) >> (FRAC + 16));
            end
            fpc_pkg::PAL_PSYCH:
            begin
                ph = t_turns(t, fpc_pkg::MUL_TURN) + tp;
                r = channel_level(255, 255, turn_sine(ph));
                g = channel_level(255, 255, turn_sine(ph + fpc_pkg::OFS_2094));
                b = channel_level(255, 255, turn_sine(ph + fpc_pkg::OFS_4188));
            end
            fpc_pkg::PAL_GRAY:
            begin
                r = channel_level(255, 255, turn_sine(t_turns(t, fpc_pkg::MUL_HALF)
                    + tp + fpc_pkg::OFS_QUART));
                g = r;
                b = r;
            end
            default:
            begin
                r = channel_level(400, 110, turn_sine(t_turns(t, fpc_pkg::MUL_K5) + tp));
                g = r;
                b = 255;
            end
        endcase
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    assign pending_colors = color_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            pal_copy <= fpc_pkg::PAL_CLASSIC;
            phase_copy <= '0;
            fail_count <= 0;
            color_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (color_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("Unexpected color %0d %0d %0d", red, green, blue);
                end
                else
                begin
                    want = color_queue.pop_front();
                    if (want != {red, green, blue})
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("Color mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want[23:16], want[15:8], want[7:0], red, green, blue);
                    end
                end
            end
            // Prediction uses the registers as they stand before any write in this cycle;
            // the user must write only while the block is idle, which it does not enforce.
            if (in_valid && !in_stall)
                color_queue.push_back(predict_color(t_value));
            if (cfg_we)
            begin
                if (cfg_index == fpc_pkg::REG_PALETTE)
                    pal_copy <= cfg_data[2:0];
                else if (cfg_index == fpc_pkg::REG_PHASE)
                    phase_copy <= cfg_data;
            end
        end
    end
endmodule

FILE: tb/fractal_palette_colorizer_test.sv
// Testbench top for the fractal palette colorizer: drives pixels and register
// writes, randomizes idling, and prints the verdict. Depends on the checker.
`timescale 1ns / 1ps

module fractal_palette_colorizer_test;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] t_value;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    int          fail_count;
    int          pending_colors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    // The watchdog limit covers the longest correct wait between transfers,
    // including stalls by the receiver and the pipeline depth.
    localparam int QUIET_LIMIT = 2000;

    fractal_palette_colorizer u_top (.*);

    fractal_palette_colorizer_check u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random on its own, one decision per falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Count cycles with no transfer on either channel; a hang ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one pixel and hold it until the transfer happens. Valid stays up
    // on return so that the next pixel can follow without a gap.
    task automatic send_pixel(input logic [15:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        t_value <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait for every predicted color, then let the pipeline drain fully.
    task automatic settle;
        in_valid <= 1'b0;
        while (pending_colors != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random t values lean toward the normal 0..1.0 range, with some above it.
    function automatic logic [15:0] random_t();
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return 16'd32768;
            2: return 16'($urandom_range(31));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    initial
    begin
        logic [15:0] phases[6];
        phases = '{16'd0, 16'd65535, 16'd16384, 16'd32768, 16'd12345, 16'd49152};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fpc_pkg::REG_PALETTE;
        cfg_data = '0;
        in_valid = 1'b0;
        t_value = '0;
        out_stall = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 83;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: the field extremes under the reset registers, and
        // again under every palette code including the unused ones.
        send_pixel(16'd0);
        send_pixel(16'd32768);
        send_pixel(16'd65535);
        send_pixel(16'd1);
        for (int p = 0; p < 8; p++)
        begin
            settle();
            write_reg(fpc_pkg::REG_PALETTE, 16'(p));
            write_reg(fpc_pkg::REG_PHASE, (p == 3) ? 16'd65535 : 16'd0);
            send_pixel(16'd0);
            send_pixel(16'd32768);
            send_pixel(16'd65535);
        end

        // Random phases: idling is swapped between the sides, then switched off.
        for (int phase_no = 0; phase_no < 30; phase_no++)
        begin
            if (phase_no == 10)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 24;
            end
            else if (phase_no == 20)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            write_reg(fpc_pkg::REG_PALETTE,
                      16'((phase_no % 6 == 5) ? $urandom_range(7) : phase_no % 5));
            write_reg(fpc_pkg::REG_PHASE,
                      (phase_no < 6) ? phases[phase_no] : 16'($urandom_range(65535)));
            for (int n = 0; n < 44; n++)
                send_pixel(random_t());
        end

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
